// File: rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

  // Region geometry
  localparam int unsigned RegionBytes = 65536;
  localparam int unsigned MinBlockBytes = 32;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned OrderCount = 11;
  localparam int unsigned TopOrder = OrderCount - 1;
  localparam int unsigned TopBytes = MinBlockBytes << TopOrder;
  localparam int unsigned Granules = RegionBytes / MinBlockBytes;
  localparam int unsigned TopGranules = TopBytes / MinBlockBytes;

  localparam int unsigned GranW = $clog2(Granules);
  localparam int unsigned OrdW = $clog2(OrderCount + 1);
  localparam int unsigned TagW = 5;
  localparam int unsigned CntW = 12;
  localparam int unsigned NeedW = 17;
  localparam int unsigned GranShift = $clog2(MinBlockBytes);

  // Tag codes: 0 empty, 1+k free block of order k, AllocBit|k allocated
  localparam int unsigned AllocBit = 4;
  localparam logic [TagW-1:0] TAG_EMPTY = '0;

  // Commands and status codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOBLOCK = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [NeedW-1:0] THR_RESET = NeedW'(32768);

  // Tag memory write request
  typedef struct packed {
    logic             en;
    logic [GranW-1:0] addr;
    logic [TagW-1:0]  data;
  } tag_wr_t;

  function automatic logic [TagW-1:0] free_tag(input logic [OrdW-1:0] ord);
    return TagW'(ord) + TagW'(1);
  endfunction

  function automatic logic [TagW-1:0] alloc_tag(input logic [OrdW-1:0] ord);
    logic [TagW-1:0] t;
    t = TagW'(ord);
    t[AllocBit] = 1'b1;
    return t;
  endfunction

  function automatic logic [NeedW-1:0] blk_bytes(input logic [OrdW-1:0] ord);
    return NeedW'(MinBlockBytes) << ord;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bba_tag_mem.sv
`default_nettype none
module bba_tag_mem
  import bba_pkg::*;
(
  input  wire logic             clk_i,
  input  wire tag_wr_t          wr_i,
  input  wire logic [GranW-1:0] raddr_i,
  output logic      [TagW-1:0]  rdata_o
);

  logic [TagW-1:0] mem [Granules];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/buddy_block_allocator.sv
// Buddy allocator over a 64 KiB region, blocks of 32 B to 32 KiB, 24 B header.
// Request channel: in_valid_i/in_stall_o with cmd_i (0 alloc, 1 free),
// request_bytes_i and free_address_i. Result channel: out_valid_o/out_stall_i
// with address_o and status_o, one result per request, in order.
// Threshold register: written by cfg_we_i/cfg_wdata_i; the user must write it
// only while idle, and the block itself does not enforce it. The block state
// is one tag per 32 B granule in a 2048-entry memory with a registered read
// port, plus per-order free counts in flops. A free reads the block's tag,
// then, below top size, reads its buddy's tag and merges with a free buddy
// one order at a time before it writes the free tag; an alloc walks the
// orders and scans the tag memory at one granule per cycle for the order it
// searches (up to 2048 entries for order 0, 2 for the top order), then splits
// the block one order at a time. Requests refused at decode go straight to
// the result; a free of a block not allocated ends once its tag is read.
// One request is worked at a time; the next is accepted once the result is
// in the output register, even while that result is stalled.
// After reset a clearing pass writes every tag memory entry; no
// request is accepted during it. A stalled result holds in the output register.
`default_nettype none
module buddy_block_allocator
  import bba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] request_bytes_i,
  input  wire logic [15:0] free_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] address_o,
  output logic      [1:0]  status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SEEK, S_SCAN, S_SPLIT, S_FTAG, S_FRD, S_FCHK, S_FPUT, S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [GranW:0]        g_q, g_d;
  logic [GranW-1:0]      off_q, off_d;
  logic [OrdW-1:0]       ord_q, ord_d;
  logic [NeedW-1:0]      need_q, need_d;
  logic                  probe_v_q, probe_v_d;
  logic [GranW-1:0]      probe_g_q, probe_g_d;
  logic [CntW-1:0]       cnt_q [OrderCount];
  logic [CntW-1:0]       cnt_d [OrderCount];
  logic [NeedW-1:0]      thr_q;
  logic                  out_v_q, out_v_d;
  logic [15:0]           res_addr_q, res_addr_d;
  logic [1:0]            res_st_q, res_st_d;
  logic [15:0]           oaddr_q, oaddr_d;
  logic [1:0]            ost_q, ost_d;

  tag_wr_t               wr;
  logic [GranW-1:0]      raddr;
  logic [TagW-1:0]       rdata;

  logic [NeedW-1:0]      need_in;
  logic [OrdW-1:0]       min_ord;
  logic [15:0]           foff;
  logic [GranW-1:0]      fgran;
  logic [GranW-1:0]      bud;
  logic [GranW:0]        step;
  logic [OrdW-1:0]       tag_ord;

  bba_tag_mem u_mem (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Request decode
  assign need_in = NeedW'(request_bytes_i) + NeedW'(HeaderBytes);
  assign foff = free_address_i - 16'(HeaderBytes);
  assign fgran = foff[GranShift +: GranW];
  assign bud = off_q ^ (GranW'(1) << ord_q);
  assign step = (GranW + 1)'(1) << ord_q;
  assign tag_ord = (rdata[OrdW-1:0] > OrdW'(TopOrder)) ? OrdW'(TopOrder) : rdata[OrdW-1:0];

  // Smallest order that holds the need
  always_comb begin
    min_ord = OrdW'(TopOrder);
    for (int k = TopOrder - 1; k >= 0; k--) begin
      if (blk_bytes(OrdW'(k)) >= need_in) begin
        min_ord = OrdW'(k);
      end
    end
  end

  // Read address select
  always_comb begin
    case (state_q)
      S_IDLE:  raddr = fgran;
      S_SCAN:  raddr = g_q[GranW-1:0];
      S_FRD:   raddr = bud;
      default: raddr = off_q;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    g_d = g_q;
    off_d = off_q;
    ord_d = ord_q;
    need_d = need_q;
    probe_v_d = 1'b0;
    probe_g_d = probe_g_q;
    cnt_d = cnt_q;
    res_addr_d = res_addr_q;
    res_st_d = res_st_q;
    out_v_d = out_v_q;
    oaddr_d = oaddr_q;
    ost_d = ost_q;
    wr = '0;

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      // Clearing pass: top block starts get the top free tag
      S_CLR: begin
        wr.en = 1'b1;
        wr.addr = g_q[GranW-1:0];
        wr.data = (g_q[GranW-1:0] % GranW'(TopGranules) == '0) ?
                  free_tag(OrdW'(TopOrder)) : TAG_EMPTY;
        g_d = g_q + 1'b1;
        if (g_q[GranW-1:0] == GranW'(Granules - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          if (cmd_i == CMD_ALLOC) begin
            need_d = need_in;
            ord_d = min_ord;
            if (need_in > thr_q) begin
              res_st_d = ST_OVER;
              state_d = S_DONE;
            end else if (need_in > NeedW'(TopBytes)) begin
              res_st_d = ST_NOBLOCK;
              state_d = S_DONE;
            end else begin
              state_d = S_SEEK;
            end
          end else begin
            off_d = fgran;
            if (free_address_i < 16'(HeaderBytes) || foff[GranShift-1:0] != '0) begin
              res_st_d = ST_BADFREE;
              state_d = S_DONE;
            end else begin
              state_d = S_FTAG;
            end
          end
        end
      end
      // Find an order with free blocks
      S_SEEK: begin
        if (ord_q > OrdW'(TopOrder)) begin
          res_st_d = ST_NOBLOCK;
          state_d = S_DONE;
        end else if (cnt_q[ord_q] == '0) begin
          ord_d = ord_q + 1'b1;
        end else begin
          g_d = '0;
          state_d = S_SCAN;
        end
      end
      // Pipelined scan, lowest address first
      S_SCAN: begin
        if (probe_v_q && rdata == free_tag(ord_q)) begin
          off_d = probe_g_q;
          cnt_d[ord_q] = cnt_q[ord_q] - 1'b1;
          state_d = S_SPLIT;
        end else if (!probe_v_q && g_q >= (GranW + 1)'(Granules)) begin
          ord_d = ord_q + 1'b1;
          state_d = S_SEEK;
        end else if (g_q < (GranW + 1)'(Granules)) begin
          probe_v_d = 1'b1;
          probe_g_d = g_q[GranW-1:0];
          g_d = g_q + step;
        end
      end
      // Halve while half still holds the need
      S_SPLIT: begin
        wr.en = 1'b1;
        if (ord_q != '0 && blk_bytes(ord_q - 1'b1) >= need_q) begin
          ord_d = ord_q - 1'b1;
          wr.addr = off_q + (GranW'(1) << (ord_q - 1'b1));
          wr.data = free_tag(ord_q - 1'b1);
          cnt_d[ord_q - 1'b1] = cnt_q[ord_q - 1'b1] + 1'b1;
        end else begin
          wr.addr = off_q;
          wr.data = alloc_tag(ord_q);
          res_addr_d = {off_q, GranShift'(0)} + 16'(HeaderBytes);
          res_st_d = ST_OK;
          state_d = S_DONE;
        end
      end
      // Check the freed block's tag
      S_FTAG: begin
        if (!rdata[AllocBit]) begin
          res_st_d = ST_BADFREE;
          state_d = S_DONE;
        end else begin
          ord_d = tag_ord;
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        state_d = (ord_q >= OrdW'(TopOrder)) ? S_FPUT : S_FCHK;
      end
      // Merge with a free buddy, clear the upper start
      S_FCHK: begin
        if (rdata == free_tag(ord_q)) begin
          wr.en = 1'b1;
          wr.addr = (bud > off_q) ? bud : off_q;
          wr.data = TAG_EMPTY;
          cnt_d[ord_q] = cnt_q[ord_q] - 1'b1;
          off_d = (bud < off_q) ? bud : off_q;
          ord_d = ord_q + 1'b1;
          state_d = S_FRD;
        end else begin
          state_d = S_FPUT;
        end
      end
      S_FPUT: begin
        wr.en = 1'b1;
        wr.addr = off_q;
        wr.data = free_tag(ord_q);
        cnt_d[ord_q] = cnt_q[ord_q] + 1'b1;
        res_st_d = ST_OK;
        state_d = S_DONE;
      end
      // Hand the result to the output register
      S_DONE: begin
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          oaddr_d = res_addr_q;
          ost_d = res_st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      g_q <= '0;
      probe_v_q <= 1'b0;
      out_v_q <= 1'b0;
      thr_q <= THR_RESET;
      for (int k = 0; k < OrderCount; k++) begin
        cnt_q[k] <= (k == TopOrder) ? CntW'(Granules / TopGranules) : '0;
      end
    end else begin
      state_q <= state_d;
      g_q <= g_d;
      probe_v_q <= probe_v_d;
      out_v_q <= out_v_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    ord_q <= ord_d;
    need_q <= need_d;
    probe_g_q <= probe_g_d;
    res_addr_q <= res_addr_d;
    res_st_q <= res_st_d;
    oaddr_q <= oaddr_d;
    ost_q <= ost_d;
  end

  assign out_valid_o = out_v_q;
  assign address_o = oaddr_q;
  assign status_o = ost_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted request did not make the block busy");
  a_addr_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> address_o == '0)
    else $error("nonzero address with error status");
  a_top_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[TopOrder] <= CntW'(Granules / TopGranules))
    else $error("top-order free count too large");
`endif

endmodule
`default_nettype wire

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NGran = 2048;
  localparam int NOrd = 11;
  localparam int TopOrd = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = CMD_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [15:0] free_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] address_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  buddy_block_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .request_bytes_i,
    .free_address_i, .out_valid_o, .out_stall_i, .address_o, .status_o,
    .cfg_we_i, .cfg_wdata_i
  );

  typedef struct {
    logic [15:0] address;
    logic [1:0] status;
  } grant_t;

  // Shadow allocator state
  logic [4:0] shadow_tag[NGran];
  int shadow_cnt[NOrd];
  int shadow_thr;
  grant_t grant_q[$];
  logic [15:0] live_q[$];
  int fails = 0;
  int n_req = 0, n_ok = 0, n_nob = 0, n_over = 0, n_bad = 0;
  bit stim_done = 1'b0;

  function automatic int blk(int k);
    return 32 << k;
  endfunction

  function automatic void shadow_reset();
    for (int g = 0; g < NGran; g++) shadow_tag[g] = '0;
    for (int k = 0; k < NOrd; k++) shadow_cnt[k] = 0;
    shadow_tag[0] = 5'(1 + TopOrd);
    shadow_tag[1024] = 5'(1 + TopOrd);
    shadow_cnt[TopOrd] = 2;
    shadow_thr = 32768;
  endfunction

  function automatic grant_t predict_alloc(int bytes);
    grant_t r;
    int need, k, off, found;
    r.address = '0;
    need = bytes + HeaderBytes;
    found = 0;
    off = 0;
    if (need > shadow_thr) begin
      r.status = ST_OVER;
      return r;
    end
    if (need > TopBytes) begin
      r.status = ST_NOBLOCK;
      return r;
    end
    k = 0;
    while (k < TopOrd && blk(k) < need) k++;
    for (; k < NOrd && found == 0; k++) begin
      if (shadow_cnt[k] == 0) continue;
      for (off = 0; off < RegionBytes; off += blk(k)) begin
        if (shadow_tag[off / 32] == 5'(1 + k)) begin
          found = 1;
          break;
        end
      end
      if (found != 0) break;
    end
    if (found == 0) begin
      r.status = ST_NOBLOCK;
      return r;
    end
    shadow_tag[off / 32] = '0;
    shadow_cnt[k]--;
    while (k > 0 && blk(k) / 2 >= need) begin
      k--;
      shadow_tag[(off + blk(k)) / 32] = 5'(1 + k);
      shadow_cnt[k]++;
    end
    shadow_tag[off / 32] = 5'(32'h10 | k);
    r.address = 16'(off + HeaderBytes);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic grant_t predict_free(int addr);
    grant_t r;
    int off, k, bud;
    logic [4:0] t;
    r.address = '0;
    r.status = ST_BADFREE;
    if (addr < HeaderBytes) return r;
    off = addr - HeaderBytes;
    if (off % 32 != 0 || off >= RegionBytes) return r;
    t = shadow_tag[off / 32];
    if (t[AllocBit] == 1'b0) return r;
    k = int'(t[3:0]);
    if (k > TopOrd) k = TopOrd;
    while (k < TopOrd) begin
      bud = off ^ blk(k);
      if (shadow_tag[bud / 32] != 5'(1 + k)) break;
      shadow_tag[bud / 32] = '0;
      shadow_cnt[k]--;
      shadow_tag[off / 32] = '0;
      if (bud < off) off = bud;
      k++;
    end
    shadow_tag[off / 32] = 5'(1 + k);
    shadow_cnt[k]++;
    r.status = ST_OK;
    return r;
  endfunction

  // Drive one request and queue its expected grant
  task automatic send_request(logic cmd, logic [15:0] bytes, logic [15:0] addr,
                              bit fixed, logic [1:0] st, logic [15:0] ad);
    grant_t e;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    request_bytes_i <= bytes;
    free_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    e = (cmd == CMD_ALLOC) ? predict_alloc(int'(bytes)) : predict_free(int'(addr));
    if (fixed && (e.status != st || e.address != ad)) begin
      $display("%0t directed row mismatch: expected st=%0d addr=%0h, model st=%0d addr=%0h",
               $time, st, ad, e.status, e.address);
      fails++;
    end
    if (cmd == CMD_ALLOC && e.status == ST_OK) live_q.push_back(e.address);
    grant_q.push_back(e);
    n_req++;
  endtask

  task automatic drain_and_config(logic [16:0] thr);
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_thr = int'(thr);
  endtask

  // Result checker with random stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    grant_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t unexpected grant addr=%0h st=%0d", $time, address_o, status_o);
          fails++;
        end else begin
          e = grant_q.pop_front();
          if (e.address !== address_o || e.status !== status_o) begin
            $display("%0t grant mismatch: expected addr=%0h st=%0d, got addr=%0h st=%0d",
                     $time, e.address, e.status, address_o, status_o);
            fails++;
          end
          case (e.status)
            ST_OK: n_ok++;
            ST_NOBLOCK: n_nob++;
            ST_OVER: n_over++;
            default: n_bad++;
          endcase
        end
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  typedef struct {
    logic cmd;
    logic [15:0] bytes;
    logic [15:0] addr;
    bit fixed;
    logic [1:0] st;
    logic [15:0] ad;
  } row_t;

  row_t rows[] = '{
    '{CMD_FREE, 16'd0, 16'd24, 1, ST_BADFREE, 16'd0},        // free of free block
    '{CMD_ALLOC, 16'd0, 16'd0, 1, ST_OK, 16'd24},            // smallest block
    '{CMD_ALLOC, 16'd8, 16'd0, 1, ST_OK, 16'd56},            // need exactly 32
    '{CMD_ALLOC, 16'd9, 16'd0, 0, 2'd0, 16'd0},
    '{CMD_ALLOC, 16'd32744, 16'd0, 0, 2'd0, 16'd0},          // whole top block
    '{CMD_ALLOC, 16'd32745, 16'd0, 1, ST_OVER, 16'd0},
    '{CMD_ALLOC, 16'hFFFF, 16'd0, 1, ST_OVER, 16'd0},
    '{CMD_ALLOC, 16'd32744, 16'd0, 1, ST_NOBLOCK, 16'd0},    // none left
    '{CMD_FREE, 16'd0, 16'd0, 1, ST_BADFREE, 16'd0},         // below header
    '{CMD_FREE, 16'd0, 16'd25, 1, ST_BADFREE, 16'd0},        // off granule
    '{CMD_FREE, 16'd0, 16'hFFFF, 1, ST_BADFREE, 16'd0},
    '{CMD_FREE, 16'd0, 16'd88, 0, 2'd0, 16'd0},              // free unsplit tail
    '{CMD_FREE, 16'd0, 16'd56, 0, 2'd0, 16'd0},
    '{CMD_FREE, 16'd0, 16'd56, 1, ST_BADFREE, 16'd0},        // double free
    '{CMD_FREE, 16'd0, 16'd24, 0, 2'd0, 16'd0},              // cascade merge
    '{CMD_FREE, 16'd0, 16'd32792, 0, 2'd0, 16'd0},
    '{CMD_FREE, 16'd0, 16'h8000, 1, ST_BADFREE, 16'd0}
  };

  initial begin
    int pick, idx, big;
    shadow_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      send_request(rows[i].cmd, rows[i].bytes, rows[i].addr, rows[i].fixed,
                   rows[i].st, rows[i].ad);
    live_q.delete();
    // Threshold sweep: fixed values, one random value, then the reset value
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: drain_and_config(17'd0);
        1: drain_and_config(17'd65536);
        2: drain_and_config(17'h1FFFF);
        3: drain_and_config(17'd24);
        4: drain_and_config(17'($urandom_range(24, 40000)));
        default: drain_and_config(17'd32768);
      endcase
      for (int n = 0; n < 320; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          big = $urandom_range(0, 49);
          send_request(CMD_ALLOC, big == 0 ? 16'($urandom) :
                       big < 5 ? 16'($urandom_range(0, 16000)) :
                       16'($urandom_range(0, 300)), 16'($urandom), 0, 0, 0);
        end else if (pick < 92 && live_q.size() != 0) begin
          idx = $urandom_range(0, live_q.size() - 1);
          send_request(CMD_FREE, 16'($urandom), live_q[idx], 0, 0, 0);
          live_q.delete(idx);
        end else begin
          send_request(CMD_FREE, 16'($urandom), $urandom_range(0, 1) ? 16'($urandom) :
                       16'($urandom_range(0, 2047) * 32 + 24), 0, 0, 0);
        end
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Completion and limit
  initial begin
    wait (stim_done);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("requests %0d: ok %0d, no block %0d, over threshold %0d, bad free %0d",
             n_req, n_ok, n_nob, n_over, n_bad);
    if (fails == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #500ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
